[hdl/character_lcd_nibble_writer_macros.svh]
// assertion macros for the character lcd nibble writer
// used by the top level only, no other dependencies
`ifndef CHARACTER_LCD_NIBBLE_WRITER_MACROS_SVH
`define CHARACTER_LCD_NIBBLE_WRITER_MACROS_SVH

// same-cycle implication, checked while out of reset
`define LCDNW_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define LCDNW_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/lcdnw_pkg.sv]
// shared types and constants for the character lcd nibble writer
// no dependencies
`default_nettype none

package lcdnw_pkg;

    // request codes
    typedef enum logic [2:0] {
        ACT_CMD    = 3'd0,
        ACT_CHAR   = 3'd1,
        ACT_CURSOR = 3'd2,
        ACT_NUMBER = 3'd3,
        ACT_INIT   = 3'd4
    } t_action;

    // configuration register indexes
    localparam logic [1:0] REG_FUNCTION_SET = 2'd0;
    localparam logic [1:0] REG_DISPLAY_ON   = 2'd1;
    localparam logic [1:0] REG_CLEAR        = 2'd2;
    localparam logic [1:0] REG_ENTRY_MODE   = 2'd3;

    localparam logic [7:0] RST_FUNCTION_SET = 8'h28;
    localparam logic [7:0] RST_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0] RST_CLEAR        = 8'h01;
    localparam logic [7:0] RST_ENTRY_MODE   = 8'h06;

    localparam logic [7:0] MODE_NIBBLE   = 8'h02;
    localparam logic [7:0] ROW0_BASE     = 8'h80;
    localparam logic [7:0] ROW1_BASE     = 8'hC0;
    localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;   // '0' is 0x30

    // x / 10 == (x * 52429) >> 19 for every 16-bit x
    localparam logic [31:0] DIV10_RECIP = 32'd52429;
    localparam int          DIV10_SHIFT = 19;

    localparam int NUM_DIGITS = 5;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    // init sequence steps
    localparam logic [2:0] INIT_MODE  = 3'd0;
    localparam logic [2:0] INIT_FUNC  = 3'd1;
    localparam logic [2:0] INIT_DISP  = 3'd2;
    localparam logic [2:0] INIT_CLEAR = 3'd3;
    localparam logic [2:0] INIT_ENTRY = 3'd4;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  byte_value;
        logic        row;
        logic [5:0]  column;
        logic [15:0] number;
    } t_request;

    typedef struct packed {
        logic       register_select;
        logic [3:0] nibble;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [7:0] function_set_command;
        logic [7:0] display_on_command;
        logic [7:0] clear_command;
        logic [7:0] entry_mode_command;
    } t_cfg;

    // one queued byte transfer; single sends only byte_val[3:0]
    typedef struct packed {
        logic       rs;
        logic       single;
        logic       last;
        logic [7:0] byte_val;
    } t_xfer;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_DIV,
        FS_EMIT
    } t_front_state;

endpackage

`default_nettype wire

[hdl/lcdnw_front.sv]
// front end: accepts requests, extracts decimal digits, pushes byte transfers
// depends on lcdnw_pkg
`default_nettype none

module lcdnw_front
    import lcdnw_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_request i_request,
    input  wire t_cfg     i_cfg,
    input  wire t_q_stat  i_q_stat,
    output logic          o_busy,
    output logic          o_push,
    output t_xfer         o_xfer
);

    t_front_state r_state, n_state;
    t_action      r_act, n_act;
    logic [7:0]   r_byte, n_byte;
    logic [15:0]  r_num, n_num;
    logic [3:0]   r_dig [NUM_DIGITS];
    logic [2:0]   r_ndig, n_ndig;
    logic [2:0]   r_idx, n_idx;
    logic         w_shift;

    logic [31:0]  w_prod;
    logic [12:0]  w_quot;
    logic [15:0]  w_q10;
    logic [3:0]   w_rem;
    logic [2:0]   w_top;

    // one decimal digit per cycle by reciprocal multiply
    assign w_prod = 32'(r_num) * DIV10_RECIP;
    assign w_quot = w_prod[31:DIV10_SHIFT];
    assign w_q10  = 16'({w_quot, 3'b000}) + 16'({w_quot, 1'b0});
    assign w_rem  = 4'(r_num - w_q10);
    assign w_top  = r_ndig - 3'd1;

    assign o_busy = (r_state != FS_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act  <= n_act;
        r_byte <= n_byte;
        r_num  <= n_num;
        r_ndig <= n_ndig;
        r_idx  <= n_idx;
        if (w_shift) begin
            r_dig[0] <= w_rem;
            for (int i = 1; i < NUM_DIGITS; i++) begin
                r_dig[i] <= r_dig[i-1];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_act   = r_act;
        n_byte  = r_byte;
        n_num   = r_num;
        n_ndig  = r_ndig;
        n_idx   = r_idx;
        w_shift = 1'b0;
        o_push  = 1'b0;
        o_xfer  = '0;
        case (r_state)
            FS_IDLE: begin
                if (i_start) begin
                    n_act = t_action'(i_request.action);
                    // step counter for init, digit index for print number
                    n_idx = INIT_MODE;
                    case (t_action'(i_request.action))
                        ACT_CMD, ACT_CHAR: begin
                            n_byte  = i_request.byte_value;
                            n_state = FS_EMIT;
                        end
                        ACT_CURSOR: begin
                            n_byte  = (i_request.row ? ROW1_BASE : ROW0_BASE)
                                      + {2'b00, i_request.column};
                            n_state = FS_EMIT;
                        end
                        ACT_NUMBER: begin
                            n_num   = i_request.number;
                            n_ndig  = 3'd0;
                            n_state = FS_DIV;
                        end
                        ACT_INIT: begin
                            n_state = FS_EMIT;
                        end
                        default: begin
                            n_state = FS_IDLE;  // undefined codes give nothing
                        end
                    endcase
                end
            end
            FS_DIV: begin
                // zero still yields a single digit
                w_shift = 1'b1;
                n_num   = {3'b000, w_quot};
                n_ndig  = r_ndig + 3'd1;
                if (w_quot == '0) begin
                    n_state = FS_EMIT;
                end
            end
            FS_EMIT: begin
                if (!i_q_stat.full) begin
                    o_push = 1'b1;
                    case (r_act)
                        ACT_NUMBER: begin
                            // most significant digit sits in entry 0
                            o_xfer.rs       = 1'b1;
                            o_xfer.byte_val = {ASCII_DIGIT_HI, r_dig[r_idx]};
                            o_xfer.last     = (r_idx == w_top);
                            n_idx           = r_idx + 3'd1;
                            if (r_idx == w_top) begin
                                n_state = FS_IDLE;
                            end
                        end
                        ACT_INIT: begin
                            n_idx = r_idx + 3'd1;
                            case (r_idx)
                                INIT_MODE: begin
                                    o_xfer.single   = 1'b1;
                                    o_xfer.byte_val = MODE_NIBBLE;
                                end
                                INIT_FUNC:  o_xfer.byte_val = i_cfg.function_set_command;
                                INIT_DISP:  o_xfer.byte_val = i_cfg.display_on_command;
                                INIT_CLEAR: o_xfer.byte_val = i_cfg.clear_command;
                                default: begin
                                    o_xfer.byte_val = i_cfg.entry_mode_command;
                                    o_xfer.last     = 1'b1;
                                    n_state         = FS_IDLE;
                                end
                            endcase
                        end
                        default: begin
                            o_xfer.rs       = (r_act == ACT_CHAR);
                            o_xfer.byte_val = r_byte;
                            o_xfer.last     = 1'b1;
                            n_state         = FS_IDLE;
                        end
                    endcase
                end
            end
            default: begin
                n_state = FS_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[hdl/lcdnw_fifo.sv]
// short queue of byte transfers between front and back ends
// depends on lcdnw_pkg
`default_nettype none

module lcdnw_fifo
    import lcdnw_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_xfer i_wdata,
    input  wire logic  i_pop,
    output t_xfer      o_rdata,
    output t_q_stat    o_stat
);

    t_xfer              r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wptr, r_rptr;
    logic [QCNT_W-1:0]  r_count;
    logic               w_do_push, w_do_pop;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == QCNT_W'(QDEPTH));
    assign w_do_push    = i_push && !o_stat.full;
    assign w_do_pop     = i_pop && !o_stat.empty;
    assign o_rdata      = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (w_do_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

[hdl/lcdnw_back.sv]
// back end: splits queued bytes into nibbles, one result per cycle while the queue holds transfers
// depends on lcdnw_pkg
`default_nettype none

module lcdnw_back
    import lcdnw_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_xfer   i_head,
    input  wire t_q_stat i_q_stat,
    output logic         o_pop,
    output logic         o_strobe,
    output t_result      o_result
);

    logic    r_phase, n_phase;
    logic    r_strobe, n_strobe;
    t_result r_result, n_result;

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    always_comb begin
        n_phase  = r_phase;
        n_strobe = 1'b0;
        n_result = r_result;
        o_pop    = 1'b0;
        if (!i_q_stat.empty) begin
            n_strobe                 = 1'b1;
            n_result.register_select = i_head.rs;
            if (i_head.single || r_phase) begin
                // low nibble ends this transfer
                n_result.nibble = i_head.byte_val[3:0];
                n_result.last   = i_head.last;
                n_phase         = 1'b0;
                o_pop           = 1'b1;
            end else begin
                n_result.nibble = i_head.byte_val[7:4];
                n_result.last   = 1'b0;
                n_phase         = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/character_lcd_nibble_writer.sv]
// top level of the character lcd nibble writer (4-bit lcd interface)
// depends on lcdnw_pkg, lcdnw_front, lcdnw_fifo, lcdnw_back and the macro header
//
// usage
//   request channel: drive i_request and raise start; the transaction is taken
//   at a rising edge with start high and busy low. busy stays high while the
//   front end works on one request.
//   result channel: each nibble appears on o_result for exactly one cycle with
//   o_strobe high; last marks the final nibble of a request. the receiver
//   cannot stall, so no ready exists on this side.
//   config: apb-style port, four 8-bit init command registers at byte
//   addresses 0, 4, 8 and 12; pready is tied high; write only when idle.
// flow
//   a taken command, character, cursor or init request goes through the front
//   end's emit state, the queue and the back end's result register to reach
//   o_result; print number first runs the divide-by-ten step per digit.
//   results stream at one nibble per cycle while the queue holds transfers,
//   set by the single back end. busy covers the emit of a byte request, the
//   five init steps or a divide and an emit per digit of print number, and
//   grows while the front end waits on a full queue; the 4-entry queue lets
//   the next request start while nibbles of the previous one still drain.
// reset
//   synchronous, active low: queue empties, no strobe, init registers return
//   to 0x28, 0x0C, 0x01, 0x06.
`default_nettype none

`include "character_lcd_nibble_writer_macros.svh"

module character_lcd_nibble_writer
    import lcdnw_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        start,
    input  wire t_request    i_request,
    output logic             busy,
    // result channel
    output logic             o_strobe,
    output t_result          o_result,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_cfg    r_cfg;
    logic    w_cfg_wr;
    logic    w_push, w_pop;
    t_xfer   w_push_xfer, w_head;
    t_q_stat w_q_stat;
    logic    w_take_defined;

    // config writes complete in the access phase
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.function_set_command <= RST_FUNCTION_SET;
            r_cfg.display_on_command   <= RST_DISPLAY_ON;
            r_cfg.clear_command        <= RST_CLEAR;
            r_cfg.entry_mode_command   <= RST_ENTRY_MODE;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_FUNCTION_SET: r_cfg.function_set_command <= pwdata[7:0];
                REG_DISPLAY_ON:   r_cfg.display_on_command   <= pwdata[7:0];
                REG_CLEAR:        r_cfg.clear_command        <= pwdata[7:0];
                default:          r_cfg.entry_mode_command   <= pwdata[7:0];
            endcase
        end
    end

    // register readback, upper bits read as zero
    always_comb begin
        case (paddr[3:2])
            REG_FUNCTION_SET: prdata = {24'h0, r_cfg.function_set_command};
            REG_DISPLAY_ON:   prdata = {24'h0, r_cfg.display_on_command};
            REG_CLEAR:        prdata = {24'h0, r_cfg.clear_command};
            default:          prdata = {24'h0, r_cfg.entry_mode_command};
        endcase
    end

    // front end: classify the request, build byte transfers
    lcdnw_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_request (i_request),
        .i_cfg     (r_cfg),
        .i_q_stat  (w_q_stat),
        .o_busy    (busy),
        .o_push    (w_push),
        .o_xfer    (w_push_xfer)
    );

    // decoupling queue
    lcdnw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_push_xfer),
        .i_pop   (w_pop),
        .o_rdata (w_head),
        .o_stat  (w_q_stat)
    );

    // back end: nibble sequencing and registered result
    lcdnw_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // a taken request with a defined code
    assign w_take_defined = start && !busy && (i_request.action <= ACT_INIT);

    // a taken request always leaves the front end busy,
    // unless its code is undefined
    `LCDNW_ASSERT_NXT(a_busy_after_start, i_clk, i_rst_n, w_take_defined, busy, "busy not raised")
    // the front end never pushes into a full queue
    `LCDNW_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, w_push, !w_q_stat.full, "push while full")
    // nibbles of one request come out without gaps
    `LCDNW_ASSERT_NXT(a_no_gap, i_clk, i_rst_n, o_strobe && !o_result.last, o_strobe, "nibble gap")

endmodule

`default_nettype wire

[sim/tb_character_lcd_nibble_writer.sv]
`timescale 1ns / 1ps
// self-checking testbench for the character lcd nibble writer
// depends on lcdnw_pkg and the character_lcd_nibble_writer rtl

module tb_character_lcd_nibble_writer;
    import lcdnw_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 10;
    // quiet cycles before a register write, covers requests that give no nibbles
    localparam int SETTLE_CYCLES  = 16;
    // quiet cycles after the last expected nibble
    localparam int TAIL_CYCLES    = 32;
    localparam int TIMEOUT_CYCLES = 250_000;
    localparam int PHASE_ITEMS    = 66;
    localparam int NUM_PHASES     = 6;
    localparam int DECIMAL_BASE   = 10;

    // request codes the block must ignore
    localparam logic [2:0] ACT_RESERVED_FIRST = 3'd5;
    localparam logic [2:0] ACT_RESERVED_LAST  = 3'd7;

    typedef enum logic [1:0] {
        JOB_REQUEST,
        JOB_REG_WRITE,
        JOB_QUIESCE
    } t_job_kind;

    typedef struct packed {
        t_job_kind   kind;
        t_request    req;
        logic [3:0]  gap;
        logic [1:0]  reg_index;
        logic [31:0] reg_data;
    } t_job;

    typedef enum logic [2:0] {
        DRV_IDLE,
        DRV_GAP,
        DRV_START,
        DRV_SETUP,
        DRV_ACCESS,
        DRV_WAIT_EMPTY,
        DRV_SETTLE
    } t_drv_state;

    // clock, reset and every block input start at known values
    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        start    = 1'b0;
    t_request    lcd_request = '0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;

    logic        busy;
    logic        o_strobe;
    t_result     o_result;
    logic [31:0] prdata;
    logic        pready;

    // scoreboard side
    t_job        lcd_jobs[$];
    t_result     nibbles_due[$];
    t_cfg        init_regs = '{function_set_command: RST_FUNCTION_SET,
                               display_on_command:   RST_DISPLAY_ON,
                               clear_command:        RST_CLEAR,
                               entry_mode_command:   RST_ENTRY_MODE};
    int          errors          = 0;
    int          requests_sent   = 0;
    int          requests_taken  = 0;
    bit          gaps_on         = 1'b1;
    t_drv_state  drv_state       = DRV_IDLE;

    character_lcd_nibble_writer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_request  (lcd_request),
        .busy       (busy),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // -------------------------------------------------------------------------
    // nibble predictor: expands one taken request into its nibble run, using
    // the init command values that were in force when the request was taken
    // -------------------------------------------------------------------------
    task automatic expand_request(input t_request r);
        logic [8:0]  byte_seq[$];   // {register_select, byte}, high nibble goes first
        logic [3:0]  digits[$];
        t_result     run[$];
        t_result     nib;
        logic [15:0] value;
        logic [7:0]  cursor_addr;
        begin
            nib = '0;
            case (r.action)
                ACT_CMD:  byte_seq.push_back({1'b0, r.byte_value});
                ACT_CHAR: byte_seq.push_back({1'b1, r.byte_value});
                ACT_CURSOR: begin
                    // 6-bit column on top of 0x80 or 0xc0 never wraps
                    cursor_addr = (r.row ? ROW1_BASE : ROW0_BASE) + {2'b00, r.column};
                    byte_seq.push_back({1'b0, cursor_addr});
                end
                ACT_NUMBER: begin
                    // decimal digits, most significant first, no leading zeros
                    value = r.number;
                    while (value != 0) begin
                        digits.push_front(4'(value % DECIMAL_BASE));
                        value = value / DECIMAL_BASE;
                    end
                    if (digits.size() == 0) begin
                        digits.push_back(4'd0);
                    end
                    foreach (digits[i]) begin
                        byte_seq.push_back({1'b1, ASCII_DIGIT_HI, digits[i]});
                    end
                end
                ACT_INIT: begin
                    // lone mode nibble on the command register, then the four commands
                    nib.nibble = MODE_NIBBLE[3:0];
                    run.push_back(nib);
                    byte_seq.push_back({1'b0, init_regs.function_set_command});
                    byte_seq.push_back({1'b0, init_regs.display_on_command});
                    byte_seq.push_back({1'b0, init_regs.clear_command});
                    byte_seq.push_back({1'b0, init_regs.entry_mode_command});
                end
                default: ;   // reserved codes give nothing
            endcase
            foreach (byte_seq[i]) begin
                nib.register_select = byte_seq[i][8];
                nib.nibble          = byte_seq[i][7:4];
                run.push_back(nib);
                nib.nibble          = byte_seq[i][3:0];
                run.push_back(nib);
            end
            if (run.size() != 0) begin
                nib      = run.pop_back();
                nib.last = 1'b1;
                run.push_back(nib);
            end
            foreach (run[i]) begin
                nibbles_due.push_back(run[i]);
            end
        end
    endtask

    // -------------------------------------------------------------------------
    // monitor: checks every strobed nibble against the oldest one due, and
    // feeds the predictor with taken requests and register writes
    // -------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_result due;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (nibbles_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected nibble rs=%0d nibble=%h last=%0d", $time,
                             o_result.register_select, o_result.nibble, o_result.last);
                end else begin
                    due = nibbles_due.pop_front();
                    if (o_result.register_select !== due.register_select ||
                        o_result.nibble !== due.nibble || o_result.last !== due.last) begin
                        errors++;
                        $display("%0t: nibble mismatch, expected rs=%0d nibble=%h last=%0d, got rs=%0d nibble=%h last=%0d",
                                 $time, due.register_select, due.nibble, due.last,
                                 o_result.register_select, o_result.nibble, o_result.last);
                    end
                end
            end
            // request transaction taken
            if (start && !busy) begin
                expand_request(lcd_request);
                requests_taken++;
            end
            // register write transaction, byte address 4 * index
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_FUNCTION_SET: init_regs.function_set_command = pwdata[7:0];
                    REG_DISPLAY_ON:   init_regs.display_on_command   = pwdata[7:0];
                    REG_CLEAR:        init_regs.clear_command        = pwdata[7:0];
                    REG_ENTRY_MODE:   init_regs.entry_mode_command   = pwdata[7:0];
                    default: ;
                endcase
            end
        end
    end

    // -------------------------------------------------------------------------
    // driver: works through lcd_jobs at the falling edge. next values are
    // built in locals and each input gets a single nonblocking update, so a
    // start that stays high for a back-to-back request is never dropped
    // -------------------------------------------------------------------------
    always @(negedge i_clk) begin : driver
        logic        n_start;
        t_request    n_request;
        logic        n_psel;
        logic        n_penable;
        logic        n_pwrite;
        logic [3:0]  n_paddr;
        logic [31:0] n_pwdata;
        logic        fetch;
        t_job        job;
        int          gap_left;
        int          settle_left;
        t_request    held_req;

        n_start   = start;
        n_request = lcd_request;
        n_psel    = psel;
        n_penable = penable;
        n_pwrite  = pwrite;
        n_paddr   = paddr;
        n_pwdata  = pwdata;
        fetch     = 1'b0;

        if (i_rst_n) begin
            case (drv_state)
                DRV_IDLE: fetch = 1'b1;
                DRV_GAP: begin
                    gap_left--;
                    if (gap_left <= 0) begin
                        n_request = held_req;
                        n_start   = 1'b1;
                        requests_sent++;
                        drv_state = DRV_START;
                    end
                end
                DRV_START: begin
                    // the monitor counts the transaction at the rising edge
                    if (requests_taken == requests_sent) begin
                        n_start = 1'b0;
                        fetch   = 1'b1;
                    end
                end
                DRV_SETUP: begin
                    n_penable = 1'b1;
                    drv_state = DRV_ACCESS;
                end
                DRV_ACCESS: begin
                    // pready is always high, so the write landed
                    n_psel    = 1'b0;
                    n_penable = 1'b0;
                    n_pwrite  = 1'b0;
                    fetch     = 1'b1;
                end
                DRV_WAIT_EMPTY: begin
                    if (nibbles_due.size() == 0 && !busy) begin
                        settle_left = SETTLE_CYCLES;
                        drv_state   = DRV_SETTLE;
                    end
                end
                DRV_SETTLE: begin
                    settle_left--;
                    if (settle_left <= 0) begin
                        fetch = 1'b1;
                    end
                end
                default: drv_state = DRV_IDLE;
            endcase

            if (fetch) begin
                if (lcd_jobs.size() == 0) begin
                    drv_state = DRV_IDLE;
                end else begin
                    job = lcd_jobs.pop_front();
                    case (job.kind)
                        JOB_REQUEST: begin
                            if (job.gap == 0) begin
                                n_request = job.req;
                                n_start   = 1'b1;
                                requests_sent++;
                                drv_state = DRV_START;
                            end else begin
                                held_req  = job.req;
                                gap_left  = job.gap;
                                drv_state = DRV_GAP;
                            end
                        end
                        JOB_REG_WRITE: begin
                            // setup cycle
                            n_psel    = 1'b1;
                            n_penable = 1'b0;
                            n_pwrite  = 1'b1;
                            n_paddr   = {job.reg_index, 2'b00};
                            n_pwdata  = job.reg_data;
                            drv_state = DRV_SETUP;
                        end
                        default: drv_state = DRV_WAIT_EMPTY;
                    endcase
                end
            end
        end

        start       <= n_start;
        lcd_request <= n_request;
        psel        <= n_psel;
        penable     <= n_penable;
        pwrite      <= n_pwrite;
        paddr       <= n_paddr;
        pwdata      <= n_pwdata;
    end

    // -------------------------------------------------------------------------
    // job builders
    // -------------------------------------------------------------------------
    function automatic t_request make_request(input logic [2:0] action,
                                              input logic [7:0] byte_value,
                                              input logic row,
                                              input logic [5:0] column,
                                              input logic [15:0] number);
        t_request r;
        r.action     = action;
        r.byte_value = byte_value;
        r.row        = row;
        r.column     = column;
        r.number     = number;
        return r;
    endfunction

    // random content; unused fields stay random too since they must be ignored
    function automatic t_request random_request();
        t_request    r;
        int unsigned pick;
        r.byte_value = 8'($urandom);
        r.row        = 1'($urandom);
        r.column     = 6'($urandom);
        // spread the digit count from one to five, plus zero
        case ($urandom_range(0, 5))
            0:       r.number = 16'($urandom_range(0, 9));
            1:       r.number = 16'($urandom_range(10, 99));
            2:       r.number = 16'($urandom_range(100, 999));
            3:       r.number = 16'($urandom_range(1000, 9999));
            4:       r.number = 16'($urandom);
            default: r.number = '0;
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 20)      r.action = ACT_CMD;
        else if (pick < 40) r.action = ACT_CHAR;
        else if (pick < 55) r.action = ACT_CURSOR;
        else if (pick < 80) r.action = ACT_NUMBER;
        else if (pick < 90) r.action = ACT_INIT;
        else                r.action = 3'($urandom_range(ACT_RESERVED_FIRST, ACT_RESERVED_LAST));
        return r;
    endfunction

    task automatic queue_request(input t_request r);
        t_job job;
        begin
            job       = '0;
            job.kind  = JOB_REQUEST;
            job.req   = r;
            job.gap   = gaps_on ? 4'($urandom_range(0, 15)) : 4'd0;
            lcd_jobs.push_back(job);
        end
    endtask

    // upper data bits are random, only the low byte is kept
    task automatic queue_reg_write(input logic [1:0] index, input logic [7:0] value);
        t_job job;
        begin
            job           = '0;
            job.kind      = JOB_REG_WRITE;
            job.reg_index = index;
            job.reg_data  = {24'($urandom), value};
            lcd_jobs.push_back(job);
        end
    endtask

    // sender holds off until every due nibble has come out
    task automatic queue_quiesce();
        t_job job;
        begin
            job      = '0;
            job.kind = JOB_QUIESCE;
            lcd_jobs.push_back(job);
        end
    endtask

    // -------------------------------------------------------------------------
    // stimulus and end of run
    // -------------------------------------------------------------------------
    initial begin : stimulus
        logic [7:0] fs_val;
        logic [7:0] disp_val;
        logic [7:0] clr_val;
        logic [7:0] entry_val;

        // directed part, init registers at their reset values
        queue_request(make_request(ACT_INIT, 8'h00, 1'b0, 6'd0, 16'd0));
        queue_request(make_request(ACT_CMD, 8'h00, 1'b1, 6'd63, 16'hFFFF));
        queue_request(make_request(ACT_CMD, 8'hFF, 1'b0, 6'd0, 16'h0000));
        queue_request(make_request(ACT_CHAR, 8'h00, 1'b1, 6'd63, 16'hFFFF));
        queue_request(make_request(ACT_CHAR, 8'hFF, 1'b0, 6'd0, 16'd0));
        queue_request(make_request(ACT_CHAR, 8'hA5, 1'b1, 6'd21, 16'd1234));
        // cursor corners: both rows, first and last column
        queue_request(make_request(ACT_CURSOR, 8'hFF, 1'b0, 6'd0, 16'd0));
        queue_request(make_request(ACT_CURSOR, 8'h00, 1'b0, 6'd63, 16'hFFFF));
        queue_request(make_request(ACT_CURSOR, 8'hFF, 1'b1, 6'd0, 16'd0));
        queue_request(make_request(ACT_CURSOR, 8'h00, 1'b1, 6'd63, 16'hFFFF));
        // zero prints as one digit, then digit-count edges
        queue_request(make_request(ACT_NUMBER, 8'hFF, 1'b1, 6'd63, 16'd0));
        queue_request(make_request(ACT_NUMBER, 8'h00, 1'b0, 6'd0, 16'd9));
        queue_request(make_request(ACT_NUMBER, 8'h00, 1'b0, 6'd0, 16'd10));
        queue_request(make_request(ACT_NUMBER, 8'h00, 1'b0, 6'd0, 16'd100));
        queue_request(make_request(ACT_NUMBER, 8'h00, 1'b0, 6'd0, 16'd10000));
        queue_request(make_request(ACT_NUMBER, 8'h00, 1'b0, 6'd0, 16'd65535));
        queue_request(make_request(ACT_NUMBER, 8'h00, 1'b0, 6'd0, 16'd9999));
        // reserved codes are dropped without output
        queue_request(make_request(ACT_RESERVED_FIRST, 8'hFF, 1'b1, 6'd63, 16'hFFFF));
        queue_request(make_request(3'd6, 8'h5A, 1'b0, 6'd17, 16'd42));
        queue_request(make_request(ACT_RESERVED_LAST, 8'h00, 1'b1, 6'd0, 16'd0));
        queue_request(make_request(ACT_INIT, 8'hFF, 1'b1, 6'd63, 16'hFFFF));

        // random phases, each under a fresh set of init commands
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: {fs_val, disp_val, clr_val, entry_val} = '0;
                1: {fs_val, disp_val, clr_val, entry_val} = '1;
                2: {fs_val, disp_val, clr_val, entry_val} =
                       {RST_FUNCTION_SET, RST_DISPLAY_ON, RST_CLEAR, RST_ENTRY_MODE};
                default: {fs_val, disp_val, clr_val, entry_val} = 32'($urandom);
            endcase
            // writes only with the block idle
            queue_quiesce();
            queue_reg_write(REG_FUNCTION_SET, fs_val);
            queue_reg_write(REG_DISPLAY_ON, disp_val);
            queue_reg_write(REG_CLEAR, clr_val);
            queue_reg_write(REG_ENTRY_MODE, entry_val);
            queue_request(make_request(ACT_INIT, 8'($urandom), 1'($urandom), 6'($urandom),
                                       16'($urandom)));
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // stretches with and without idle gaps
                if (i % 22 == 0) begin
                    gaps_on = ($urandom_range(0, 2) != 0);
                end
                if (i == PHASE_ITEMS / 2) begin
                    queue_quiesce();
                end
                queue_request(random_request());
            end
        end

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // let the driver empty its queue, then drain the due nibbles
        @(posedge i_clk);
        while (lcd_jobs.size() != 0 || drv_state != DRV_IDLE) @(posedge i_clk);
        while (nibbles_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // hang guard
    initial begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("timeout with %0d nibbles still due", nibbles_due.size());
        $display("status: fail");
        $finish;
    end

endmodule
